>>> hdl/fts_pkg.sv
// Package for the fan tachometer speed meter: widths, register indexes,
// reset values, the queue entry and the back-end sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package fts_pkg;

    // Parameter defaults
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int PERIOD_SHIFT_DEF = 5;
    localparam int QUEUE_DEPTH      = 2;

    // Divider width: 60 * 1000000 fits in 26 bits, so do all periods and limits
    localparam int DIV_W = 26;

    localparam int PPR_W      = 5;
    localparam int RPM_W      = 16;
    localparam int WGT_W      = 11;
    localparam int WGT_BITS   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = RPM_W + WGT_W;

    localparam logic [DIV_W-1:0] US_PER_SEC = DIV_W'(1000000);
    localparam logic [WGT_W-1:0] WEIGHT_ONE = WGT_W'(1024);

    // Register reset values
    localparam logic [PPR_W-1:0] PPR_RST     = PPR_W'(2);
    localparam logic [RPM_W-1:0] MIN_RPM_RST = RPM_W'(100);
    localparam logic [RPM_W-1:0] MAX_RPM_RST = RPM_W'(3000);
    localparam logic [WGT_W-1:0] WEIGHT_RST  = WGT_W'(512);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PPR     = 2'd0,
        REG_MIN_RPM = 2'd1,
        REG_MAX_RPM = 2'd2,
        REG_WEIGHT  = 2'd3
    } t_reg_idx;

    // Input command codes
    localparam logic CMD_EDGE    = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

    typedef struct packed {
        logic [PPR_W-1:0] ppr;
        logic [RPM_W-1:0] min_rpm;
        logic [RPM_W-1:0] max_rpm;
        logic [WGT_W-1:0] weight;
    } t_cfg;

    // Queue entry: period and gap are saturated to DIV_W bits (still above any limit)
    typedef struct packed {
        logic             cmd;
        logic [DIV_W-1:0] period;
        logic [DIV_W-1:0] gap;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_DIV1 = 6'b000010,
        S_DIV2 = 6'b000100,
        S_CHK  = 6'b001000,
        S_MUL  = 6'b010000,
        S_MIX  = 6'b100000
    } t_state;

endpackage

>>> hdl/fan_tach_speed_meter.sv
// Fan tachometer speed meter, top level: configuration registers, front end,
// job queue and back end. Uses fts_pkg, fts_front, fts_fifo, fts_back.
//
// Usage: transactions go in as push/full with i_cmd (0 hall edge, 1 measure)
// and i_timestamp. Each transaction yields one result (filtered rpm and
// stall flag), read out as empty/pop, oldest first.
// An edge transaction only updates the stored edge time and period; its
// result carries the current filtered speed. A measure transaction runs
// the stall limit and the speed division in two 26-bit dividers side by
// side, each used twice (1000000/x, then *60/ppr), one quotient bit per
// cycle; the stall check and the filter's multiply and mix steps follow,
// and the two back-to-back divider passes take most of a measure's time.
// A two-entry queue sits between front and back, so the input keeps taking
// transactions while a result waits or a division runs; full rises only
// when the queue holds two and the back end is busy or its result is unread.
// Configuration is a plain write port (enable, index, 16-bit data); the user
// writes it only while the block is idle (not enforced). Reset (synchronous,
// active low) restores register defaults, clears queue, edge state, filter.
`timescale 1ns / 1ps

module fan_tach_speed_meter import fts_pkg::*; #(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int PERIOD_SHIFT = PERIOD_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_cmd,
    input  logic [TIME_WIDTH-1:0] i_timestamp,
    output logic                  empty,
    input  logic                  pop,
    output logic [RPM_W-1:0]      o_speed_rpm,
    output logic                  o_stalled,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg             r_cfg;
    t_job             front_job, back_job;
    logic [JOB_W-1:0] q_data;
    logic             accept, q_empty, q_pop, res_valid;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ppr     <= PPR_RST;
            r_cfg.min_rpm <= MIN_RPM_RST;
            r_cfg.max_rpm <= MAX_RPM_RST;
            r_cfg.weight  <= WEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PPR:     r_cfg.ppr     <= i_cfg_data[PPR_W-1:0];
                REG_MIN_RPM: r_cfg.min_rpm <= i_cfg_data[RPM_W-1:0];
                REG_MAX_RPM: r_cfg.max_rpm <= i_cfg_data[RPM_W-1:0];
                REG_WEIGHT:  r_cfg.weight  <= i_cfg_data[WGT_W-1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    assign accept = push && !full;

    fts_front #(
        .TIME_WIDTH   (TIME_WIDTH),
        .PERIOD_SHIFT (PERIOD_SHIFT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_timestamp (i_timestamp),
        .o_job       (front_job)
    );

    fts_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign back_job = t_job'(q_data);

    fts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (back_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (q_pop),
        .o_res_valid (res_valid),
        .i_res_pop   (pop),
        .o_speed_rpm (o_speed_rpm),
        .o_stalled   (o_stalled)
    );

    assign empty = !res_valid;

endmodule

>>> hdl/fts_ram.sv
// Small register queue used between the front and back ends.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module fts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/fts_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses fts_pkg for the default width.
`timescale 1ns / 1ps

module fts_div import fts_pkg::*; #(
    parameter int W = DIV_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic [W-1:0] o_quotient
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem, r_quo, r_dsr;
    logic [W:0]    trial, diff;
    logic          ge;

    // One restoring step
    assign trial = {r_rem, r_quo[W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

    // Step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

endmodule

>>> hdl/fts_front.sv
// Front end: accepts transactions, keeps the last edge time and edge period,
// and builds the queue entry for the back end. Uses fts_pkg.
`timescale 1ns / 1ps

module fts_front import fts_pkg::*; #(
    parameter int TIME_WIDTH   = TIME_WIDTH_DEF,
    parameter int PERIOD_SHIFT = PERIOD_SHIFT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_cmd,
    input  logic [TIME_WIDTH-1:0] i_timestamp,
    output t_job                  o_job
);
    localparam int PW = TIME_WIDTH - PERIOD_SHIFT;

    logic [TIME_WIDTH-1:0] r_last_edge;
    logic [DIV_W-1:0]      r_period;
    logic [TIME_WIDTH-1:0] diff;
    logic [PW-1:0]         gap_full;
    logic [DIV_W-1:0]      gap_sat;

    // Time since last edge, wrapped, scaled down
    assign diff     = i_timestamp - r_last_edge;
    assign gap_full = diff[TIME_WIDTH-1:PERIOD_SHIFT];

    // Saturate to divider width; anything that large is a stall anyway
    generate
        if (PW > DIV_W) begin : g_sat
            assign gap_sat = (|gap_full[PW-1:DIV_W]) ? '1 : gap_full[DIV_W-1:0];
        end else begin : g_ext
            assign gap_sat = DIV_W'(gap_full);
        end
    endgenerate

    always_comb begin
        o_job.cmd    = i_cmd;
        o_job.period = r_period;
        o_job.gap    = gap_sat;
    end

    // Edge transactions update the period and the edge time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_edge <= '0;
            r_period    <= DIV_W'(1);
        end else if (i_accept && (i_cmd == CMD_EDGE)) begin
            r_last_edge <= i_timestamp;
            r_period    <= gap_sat;
        end
    end

endmodule

>>> hdl/fts_back.sv
// Back end: stall limit and speed by two dividers, clamp, low-pass filter,
// and the output register. Uses fts_pkg and fts_div.
`timescale 1ns / 1ps

module fts_back import fts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_job             i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    output logic             o_res_valid,
    input  logic             i_res_pop,
    output logic [RPM_W-1:0] o_speed_rpm,
    output logic             o_stalled
);
    t_state              r_state, n_state;
    logic [DIV_W-1:0]    r_period, r_gap;
    logic [RPM_W-1:0]    r_raw, r_filt;
    logic                r_stall;
    logic [PROD_W-1:0]   r_prod_old, r_prod_new;
    logic                r_out_valid, r_out_stall;
    logic [RPM_W-1:0]    r_out_speed;

    logic [PPR_W-1:0]    ppr_eff;
    logic [RPM_W-1:0]    min_eff;
    logic [WGT_W-1:0]    w_eff, w_inv;
    logic                take, div_start, div_idle;
    logic [DIV_W-1:0]    dividend_a, dividend_b, divisor_a, divisor_b;
    logic [DIV_W-1:0]    quo_a, quo_b;
    logic                busy_a, busy_b;
    logic                stall_now;
    logic [RPM_W-1:0]    raw_now;
    logic [PROD_W:0]     mix;

    function automatic logic [DIV_W-1:0] times60(input logic [DIV_W-1:0] q);
        logic [DIV_W+5:0] t;
        t = {q, 6'b0} - {4'b0, q, 2'b0};
        return t[DIV_W-1:0];
    endfunction

    // Effective configuration
    assign ppr_eff = (i_cfg.ppr == '0) ? PPR_W'(1) : i_cfg.ppr;
    assign min_eff = (i_cfg.min_rpm == '0) ? RPM_W'(1) : i_cfg.min_rpm;
    assign w_eff   = (i_cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : i_cfg.weight;
    assign w_inv   = WEIGHT_ONE - w_eff;

    assign take      = (r_state == S_IDLE) && i_job_valid && !r_out_valid;
    assign o_job_pop = take;
    assign div_idle  = !busy_a && !busy_b;

    // Divider a: stall limit, divider b: speed
    assign div_start  = (take && (i_job.cmd == CMD_MEASURE)) ||
                        ((r_state == S_DIV1) && div_idle);
    assign dividend_a = (r_state == S_IDLE) ? US_PER_SEC : times60(quo_a);
    assign dividend_b = (r_state == S_IDLE) ? US_PER_SEC : times60(quo_b);
    assign divisor_a  = (r_state == S_IDLE) ? DIV_W'(min_eff) : DIV_W'(ppr_eff);
    assign divisor_b  = (r_state == S_IDLE) ? i_job.period : DIV_W'(ppr_eff);

    fts_div #(.W(DIV_W)) u_div_lim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend_a),
        .i_divisor  (divisor_a),
        .o_busy     (busy_a),
        .o_quotient (quo_a)
    );

    fts_div #(.W(DIV_W)) u_div_spd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend_b),
        .i_divisor  (divisor_b),
        .o_busy     (busy_b),
        .o_quotient (quo_b)
    );

    // Stall check and clamp, limit in quo_a and speed in quo_b
    always_comb begin
        stall_now = (r_period >= quo_a) || (r_gap >= quo_a);
        if (stall_now) begin
            raw_now = '0;
        end else if (r_period == '0) begin
            raw_now = i_cfg.max_rpm;
        end else if (quo_b > DIV_W'(i_cfg.max_rpm)) begin
            raw_now = i_cfg.max_rpm;
        end else begin
            raw_now = quo_b[RPM_W-1:0];
        end
    end

    assign mix = {1'b0, r_prod_old} + {1'b0, r_prod_new};

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (take && (i_job.cmd == CMD_MEASURE)) n_state = S_DIV1;
            S_DIV1: if (div_idle) n_state = S_DIV2;
            S_DIV2: if (div_idle) n_state = S_CHK;
            S_CHK:  n_state = S_MUL;
            S_MUL:  n_state = S_MIX;
            S_MIX:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filt      <= '0;
            r_stall     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CHK) begin
                r_stall <= stall_now;
            end
            if (r_state == S_MIX) begin
                r_filt <= mix[WGT_BITS+RPM_W-1:WGT_BITS];
            end
            if ((take && (i_job.cmd == CMD_EDGE)) || (r_state == S_MIX)) begin
                r_out_valid <= 1'b1;
            end else if (i_res_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_period <= i_job.period;
            r_gap    <= i_job.gap;
        end
        if (r_state == S_CHK) begin
            r_raw <= raw_now;
        end
        if (r_state == S_MUL) begin
            r_prod_old <= r_filt * w_eff;
            r_prod_new <= r_raw * w_inv;
        end
        if (take && (i_job.cmd == CMD_EDGE)) begin
            r_out_speed <= r_filt;
            r_out_stall <= r_stall;
        end else if (r_state == S_MIX) begin
            r_out_speed <= mix[WGT_BITS+RPM_W-1:WGT_BITS];
            r_out_stall <= r_stall;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_speed_rpm = r_out_speed;
    assign o_stalled   = r_out_stall;

endmodule

>>> hdl/fts_chk.sv
// Port-level checker for the fan tachometer speed meter and its bind.
// Uses fts_pkg; attaches to fan_tach_speed_meter.
`timescale 1ns / 1ps

module fts_chk import fts_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [RPM_W-1:0] o_speed_rpm,
    input logic             o_stalled
);

    // Reset drops any waiting result
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result present after reset");

    // Reset empties the queue
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input full after reset");

    // The queue only fills through an accepted push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("full rose without a push");

    // A waiting result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_speed_rpm) && $stable(o_stalled)))
        else $error("result changed before pop");

endmodule

bind fan_tach_speed_meter fts_chk u_fts_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .push        (push),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .o_speed_rpm (o_speed_rpm),
    .o_stalled   (o_stalled)
);
